FILE: sv/sle_pkg.sv
// Shared types and codes for the sequential list engine.
// Holds the transaction payloads, result codes, state machine states and the
// command and status records between controller and datapath. No dependencies.
package sle_pkg;

   // Request opcodes; codes six and seven are unused and answer OK.
   typedef enum logic [2:0] {
      ACT_CLEAR  = 3'd0,
      ACT_LOCATE = 3'd1,
      ACT_INSERT = 3'd2,
      ACT_DELETE = 3'd3,
      ACT_APPEND = 3'd4,
      ACT_PURGE  = 3'd5
   } action_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_BADPOS   = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   // Request payload.
   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] value;
      logic [6:0]         position;
   } req_type;

   // Result payload.
   typedef struct packed {
      status_type status;
      logic [5:0] found_position;
      logic [6:0] length;
      logic       is_empty;
   } rsp_type;

   // Controller states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_SHIFT_UP,
      S_SHIFT_DOWN,
      S_P_CHECK,
      S_P_FETCH,
      S_P_LATCH,
      S_P_SCAN
   } state_type;

   // Walk pointer updates.
   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_ZERO,
      PTR_COUNT,
      PTR_POS_P1,
      PTR_IDX,
      PTR_IDX_P1,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   // Entry count updates.
   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_CLEAR,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   // Purge outer index updates.
   typedef enum logic [1:0] {
      IDX_HOLD,
      IDX_ONE,
      IDX_INC
   } idx_op_type;

   // Write address and data selection.
   typedef enum logic [1:0] {
      WA_UP,
      WA_DOWN,
      WA_POS,
      WA_COUNT
   } wr_sel_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic       load_req;
      ptr_op_type ptr_op;
      logic       rd_en;
      logic       rd_below;
      logic       wr_en;
      wr_sel_type wr_sel;
      cnt_op_type cnt_op;
      idx_op_type idx_op;
      logic       cand_load;
      logic       key_cand;
      logic       respond;
      status_type rsp_status;
      logic       found_hit;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic [2:0] action;
      logic       dvalid;
      logic       hit;
      logic       full;
      logic       empty;
      logic       pos_gt_count;
      logic       pos_ge_count;
      logic       ptr_lt_count;
      logic       ptr_gt_pos;
      logic       ptr_lt_idx;
      logic       idx_lt_count;
   } stat_type;

endpackage

FILE: sv/sle_controller.sv
// Sequencing state machine of the sequential list engine.
// Walks each request through its scan, shift or purge loop by issuing
// commands to the datapath. Depends on sle_pkg.
module sle_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sle_pkg::stat_type stat,
   output sle_pkg::cmd_type  cmd
);
   import sle_pkg::*;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            unique case (action_type'(stat.action))
               ACT_CLEAR: begin
                  cmd.cnt_op  = CNT_CLEAR;
                  cmd.respond = 1'b1;
                  state_in    = S_IDLE;
               end
               ACT_LOCATE, ACT_APPEND: begin
                  cmd.ptr_op = PTR_ZERO;
                  state_in   = S_SCAN;
               end
               ACT_INSERT: begin
                  priority if (stat.full) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = ST_FULL;
                     state_in       = S_IDLE;
                  end else if (stat.pos_gt_count) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = ST_BADPOS;
                     state_in       = S_IDLE;
                  end else begin
                     cmd.ptr_op = PTR_COUNT;
                     state_in   = S_SHIFT_UP;
                  end
               end
               ACT_DELETE: begin
                  priority if (stat.empty) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = ST_EMPTY;
                     state_in       = S_IDLE;
                  end else if (stat.pos_ge_count) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = ST_BADPOS;
                     state_in       = S_IDLE;
                  end else begin
                     cmd.ptr_op = PTR_POS_P1;
                     state_in   = S_SHIFT_DOWN;
                  end
               end
               ACT_PURGE: begin
                  cmd.idx_op = IDX_ONE;
                  state_in   = S_P_CHECK;
               end
               default: begin
                  cmd.respond = 1'b1;
                  state_in    = S_IDLE;
               end
            endcase
         end

         // Linear search for the request value over the whole list.
         S_SCAN: begin
            priority if (stat.hit) begin
               cmd.respond   = 1'b1;
               cmd.found_hit = (action_type'(stat.action) == ACT_LOCATE);
               state_in      = S_IDLE;
            end else if (stat.ptr_lt_count) begin
               cmd.rd_en  = 1'b1;
               cmd.ptr_op = PTR_INC;
            end else begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
               priority if (action_type'(stat.action) == ACT_LOCATE) begin
                  cmd.rsp_status = ST_NOTFOUND;
               end else if (stat.full) begin
                  cmd.rsp_status = ST_FULL;
               end else begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_sel = WA_COUNT;
                  cmd.cnt_op = CNT_INC;
               end
            end
         end

         // Move entries up one place, top first, then drop the value in.
         S_SHIFT_UP: begin
            if (stat.dvalid) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WA_UP;
            end
            priority if (stat.ptr_gt_pos) begin
               cmd.rd_en    = 1'b1;
               cmd.rd_below = 1'b1;
               cmd.ptr_op   = PTR_DEC;
            end else if (!stat.dvalid) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = WA_POS;
               cmd.cnt_op  = CNT_INC;
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end else begin
               state_in = S_SHIFT_UP;
            end
         end

         // Move entries down one place to close the gap.
         S_SHIFT_DOWN: begin
            if (stat.dvalid) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WA_DOWN;
            end
            priority if (stat.ptr_lt_count) begin
               cmd.rd_en  = 1'b1;
               cmd.ptr_op = PTR_INC;
            end else if (!stat.dvalid) begin
               cmd.cnt_op = CNT_DEC;
               if (action_type'(stat.action) == ACT_PURGE) begin
                  state_in = S_P_CHECK;
               end else begin
                  cmd.respond = 1'b1;
                  state_in    = S_IDLE;
               end
            end else begin
               state_in = S_SHIFT_DOWN;
            end
         end

         // Purge outer loop test.
         S_P_CHECK: begin
            if (stat.idx_lt_count) begin
               cmd.ptr_op = PTR_IDX;
               state_in   = S_P_FETCH;
            end else begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end

         S_P_FETCH: begin
            cmd.rd_en = 1'b1;
            state_in  = S_P_LATCH;
         end

         S_P_LATCH: begin
            cmd.cand_load = 1'b1;
            cmd.ptr_op    = PTR_ZERO;
            state_in      = S_P_SCAN;
         end

         // Search the earlier entries for the candidate.
         S_P_SCAN: begin
            cmd.key_cand = 1'b1;
            priority if (stat.hit) begin
               cmd.ptr_op = PTR_IDX_P1;
               state_in   = S_SHIFT_DOWN;
            end else if (stat.ptr_lt_idx) begin
               cmd.rd_en  = 1'b1;
               cmd.ptr_op = PTR_INC;
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = S_P_CHECK;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/sle_datapath.sv
// Datapath of the sequential list engine: entry memory, walk pointers,
// entry count, comparator and the result register.
// Depends on sle_pkg; driven by sle_controller commands.
module sle_datapath #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  sle_pkg::req_type req_payload,
   input  sle_pkg::cmd_type cmd,
   output sle_pkg::stat_type stat,
   output logic             rsp_strobe,
   output sle_pkg::rsp_type rsp_payload
);
   import sle_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam int WW = (CW > 7) ? CW : 7;

   logic [31:0]   mem_ff [CAPACITY];
   req_type       req_ff, req_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [31:0]   cand_ff, cand_in;
   logic [31:0]   rd_data_ff;
   logic [IW-1:0] rd_addr_ff, rd_addr, wr_addr;
   logic [31:0]   wr_data, key;
   logic          dvalid_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff, rsp_in;
   logic [WW-1:0] pos_w, count_w, ptr_w, idx_w;

   // Entry memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   // Read and write address selection.
   assign rd_addr = cmd.rd_below ? IW'(ptr_ff - 1'b1) : IW'(ptr_ff);

   always_comb begin
      wr_data = rd_data_ff;
      unique case (cmd.wr_sel)
         WA_UP:    wr_addr = rd_addr_ff + 1'b1;
         WA_DOWN:  wr_addr = rd_addr_ff - 1'b1;
         WA_POS: begin
            wr_addr = IW'(req_ff.position);
            wr_data = req_ff.value;
         end
         WA_COUNT: begin
            wr_addr = IW'(count_ff);
            wr_data = req_ff.value;
         end
         default:  wr_addr = rd_addr_ff;
      endcase
   end

   // Pointer, index, count and operand next values.
   always_comb begin
      unique case (cmd.ptr_op)
         PTR_HOLD:   ptr_in = ptr_ff;
         PTR_ZERO:   ptr_in = '0;
         PTR_COUNT:  ptr_in = count_ff;
         PTR_POS_P1: ptr_in = CW'(pos_w + 1'b1);
         PTR_IDX:    ptr_in = idx_ff;
         PTR_IDX_P1: ptr_in = idx_ff + 1'b1;
         PTR_INC:    ptr_in = ptr_ff + 1'b1;
         PTR_DEC:    ptr_in = ptr_ff - 1'b1;
         default:    ptr_in = ptr_ff;
      endcase
      unique case (cmd.cnt_op)
         CNT_HOLD:  count_in = count_ff;
         CNT_CLEAR: count_in = '0;
         CNT_INC:   count_in = count_ff + 1'b1;
         CNT_DEC:   count_in = count_ff - 1'b1;
         default:   count_in = count_ff;
      endcase
      unique case (cmd.idx_op)
         IDX_HOLD: idx_in = idx_ff;
         IDX_ONE:  idx_in = CW'(1);
         IDX_INC:  idx_in = idx_ff + 1'b1;
         default:  idx_in = idx_ff;
      endcase
      cand_in = cmd.cand_load ? rd_data_ff : cand_ff;
      req_in  = cmd.load_req ? req_payload : req_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dvalid_ff    <= cmd.rd_en;
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      ptr_ff  <= ptr_in;
      idx_ff  <= idx_in;
      cand_ff <= cand_in;
      if (cmd.respond) begin
         rsp_ff <= rsp_in;
      end
   end

   // Comparator and status toward the controller.
   assign key     = cmd.key_cand ? cand_ff : req_ff.value;
   assign pos_w   = WW'(req_ff.position);
   assign count_w = WW'(count_ff);
   assign ptr_w   = WW'(ptr_ff);
   assign idx_w   = WW'(idx_ff);

   always_comb begin
      stat.action       = req_ff.action;
      stat.dvalid       = dvalid_ff;
      stat.hit          = dvalid_ff && (rd_data_ff == key);
      stat.full         = (count_ff >= CW'(CAPACITY));
      stat.empty        = (count_ff == '0);
      stat.pos_gt_count = (pos_w > count_w);
      stat.pos_ge_count = (pos_w >= count_w);
      stat.ptr_lt_count = (ptr_ff < count_ff);
      stat.ptr_gt_pos   = (ptr_w > pos_w);
      stat.ptr_lt_idx   = (ptr_w < idx_w);
      stat.idx_lt_count = (idx_w < count_w);
   end

   // Result register; length reflects the count after this request.
   always_comb begin
      rsp_in.status         = cmd.rsp_status;
      rsp_in.found_position = cmd.found_hit ? 6'(rd_addr_ff) : 6'd0;
      rsp_in.length         = 7'(count_in);
      rsp_in.is_empty       = (count_in == '0);
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: sv/sequential_list_engine_top.sv
// Top level of the sequential list engine: an ordered list of signed values.
// Instantiates sle_controller and sle_datapath; depends on sle_pkg.
//
//   channel   | ports                        | handshake
//   ----------+------------------------------+------------------------------
//   request   | start, busy, req_payload     | taken when start && !busy
//   result    | rsp_strobe, rsp_payload      | one-cycle strobe per transaction
//
// Clear, unused codes and early full, empty or bad-position answers respond from
// dispatch; locate and append-unique read one entry per cycle; insert and delete
// move the entries above the position one place at a time. Purge checks each
// entry against all earlier ones through the one read port. Synchronous reset
// empties the list; busy holds off new requests until the result, and the
// receiver cannot stall.
module sequential_list_engine_top #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sle_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output sle_pkg::rsp_type rsp_payload
);
   import sle_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   sle_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   sle_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: sv/sle_checker.sv
// Port-level checks for the sequential list engine and their bind.
// Depends on sle_pkg; attaches to sequential_list_engine_top.
module sle_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input sle_pkg::req_type req_payload,
   input logic             rsp_strobe,
   input sle_pkg::rsp_type rsp_payload
);
   import sle_pkg::*;

   // An accepted transaction keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   // A result ends the transaction: the block is free while it is shown.
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && $past(busy))
      else $error("result shown outside a transaction");

   // Results never appear in two consecutive cycles.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // A clear answers with an empty list.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_payload.action == ACT_CLEAR)
      |=> ##1 rsp_strobe && (rsp_payload.length == 7'd0) && rsp_payload.is_empty)
      else $error("clear did not return an empty list");

endmodule

bind sequential_list_engine_top sle_checker u_sle_checker (.*);
